[hdl/efkt_pkg.sv]
// Shared types and constants for the expiring full-key table.
package efkt_pkg;

  localparam int ENTRIES_DEF   = 4;
  localparam int KEY_WIDTH_DEF = 64;
  localparam int STAMP_W       = 32;
  localparam int EXP_W         = 16;
  localparam int OP_W          = 2;

  localparam logic [EXP_W-1:0] EXPIRY_RESET = 16'd60;

  localparam logic [OP_W-1:0] OP_MARK  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } state_t;

  // result of one entry compare
  typedef struct packed {
    logic key_eq;
    logic expired;
    logic older;
  } cmp_res_t;

endpackage

[hdl/efkt_entry_ram.sv]
// Key and stamp storage: one write port, one registered read port.
module efkt_entry_ram #(
  parameter int DEPTH  = efkt_pkg::ENTRIES_DEF,
  parameter int KEY_W  = efkt_pkg::KEY_WIDTH_DEF,
  parameter int ADDR_W = 2
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [KEY_W-1:0]           wkey,
  input  logic [efkt_pkg::STAMP_W-1:0] wstamp,
  input  logic                       re,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [KEY_W-1:0]           rkey,
  output logic [efkt_pkg::STAMP_W-1:0] rstamp
);

  logic [KEY_W-1:0]             key_mem   [DEPTH];
  logic [efkt_pkg::STAMP_W-1:0] stamp_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr]   <= wkey;
      stamp_mem[waddr] <= wstamp;
    end
    if (re) begin
      rkey   <= key_mem[raddr];
      rstamp <= stamp_mem[raddr];
    end
  end

endmodule

[hdl/efkt_cmp_unit.sv]
// Shared per-entry compare: key match, expiry test, oldest-stamp test.
module efkt_cmp_unit #(
  parameter int KEY_W = efkt_pkg::KEY_WIDTH_DEF
) (
  input  logic [KEY_W-1:0]             ent_key,
  input  logic [efkt_pkg::STAMP_W-1:0] ent_stamp,
  input  logic [KEY_W-1:0]             key,
  input  logic [efkt_pkg::STAMP_W-1:0] now,
  input  logic [efkt_pkg::EXP_W-1:0]   expiry,
  input  logic [efkt_pkg::STAMP_W-1:0] ref_stamp,
  output efkt_pkg::cmp_res_t           res
);

  // age kept one bit wider so a future stamp reads as negative
  logic [efkt_pkg::STAMP_W:0] age;

  assign age = {1'b0, now} - {1'b0, ent_stamp};

  always_comb begin
    res.key_eq  = (ent_key == key);
    res.expired = !age[efkt_pkg::STAMP_W] &&
                  (age[efkt_pkg::STAMP_W-1:0] >
                   efkt_pkg::STAMP_W'(expiry));
    res.older   = (ent_stamp < ref_stamp);
  end

endmodule

[hdl/expiring_full_key_table.sv]
// Top level of the expiring full-key table: sequencer, valid bits, config and result register.
//
//   channel | beat holds                    | handshake
//   --------+-------------------------------+-----------------------
//   in      | opcode, key, time_now         | in_valid / in_ready
//   out     | is_full                       | out_valid / out_ready
//   cfg     | cfg_data (expiry_seconds)     | cfg_valid / cfg_ready
//
// An item walks the entries one per cycle through the single compare unit,
// each entry's RAM read issued in the cycle before its compare. A mark scans
// every entry, writes its slot, then responds; a clear or query scans then
// responds, a query stopping early on a hit; an unused opcode just responds.
// The entry RAM read port paces the scan. Reset clears the valid bits at once;
// no clearing pass is run. A result waiting in the output register holds off
// only the next item's completion, not its acceptance. cfg is always ready.
module expiring_full_key_table #(
  parameter int ENTRIES   = efkt_pkg::ENTRIES_DEF,
  parameter int KEY_WIDTH = efkt_pkg::KEY_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [efkt_pkg::OP_W-1:0]    opcode,
  input  logic [KEY_WIDTH-1:0]         key,
  input  logic [efkt_pkg::STAMP_W-1:0] time_now,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         is_full,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [efkt_pkg::EXP_W-1:0]   cfg_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  efkt_pkg::state_t state, state_next;

  // latched item
  logic [efkt_pkg::OP_W-1:0]    cur_op;
  logic [KEY_WIDTH-1:0]         cur_key;
  logic [efkt_pkg::STAMP_W-1:0] cur_now;

  logic [efkt_pkg::EXP_W-1:0]   expiry;
  logic [ENTRIES-1:0]           entry_valid;

  // scan pointers: rd_ptr issues reads, chk_ptr follows with the data
  logic [CNT_W-1:0] rd_ptr;
  logic [IDX_W-1:0] chk_ptr;
  logic             pend;

  // scan findings
  logic                         hit;
  logic                         match_found;
  logic [IDX_W-1:0]             match_idx;
  logic                         free_found;
  logic [IDX_W-1:0]             free_idx;
  logic                         old_found;
  logic [IDX_W-1:0]             old_idx;
  logic [efkt_pkg::STAMP_W-1:0] old_stamp;

  // RAM / compare hookup
  logic [KEY_WIDTH-1:0]         ram_key;
  logic [efkt_pkg::STAMP_W-1:0] ram_stamp;
  logic                         ram_re;
  logic                         ram_we;
  logic [IDX_W-1:0]             victim;
  efkt_pkg::cmp_res_t           cmp;

  // control from the FSM
  logic accept;
  logic eval;
  logic ent_v;
  logic q_hit;
  logic scan_done;
  logic clr_en;
  logic out_load;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  efkt_entry_ram #(
    .DEPTH (ENTRIES),
    .KEY_W (KEY_WIDTH),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (victim),
    .wkey  (cur_key),
    .wstamp(cur_now),
    .re    (ram_re),
    .raddr (rd_ptr[IDX_W-1:0]),
    .rkey  (ram_key),
    .rstamp(ram_stamp)
  );

  efkt_cmp_unit #(
    .KEY_W(KEY_WIDTH)
  ) u_cmp (
    .ent_key  (ram_key),
    .ent_stamp(ram_stamp),
    .key      (cur_key),
    .now      (cur_now),
    .expiry   (expiry),
    .ref_stamp(old_stamp),
    .res      (cmp)
  );

  // per-entry decisions while scanning
  assign eval      = (state == efkt_pkg::ST_SCAN) && pend;
  assign ent_v     = entry_valid[chk_ptr];
  assign q_hit     = eval && (cur_op == efkt_pkg::OP_QUERY) && ent_v &&
                     !cmp.expired && cmp.key_eq;
  assign scan_done = eval && ((chk_ptr == IDX_LAST) || q_hit);

  always_comb begin
    clr_en = 1'b0;
    if (eval && ent_v) begin
      unique case (cur_op)
        efkt_pkg::OP_CLEAR: clr_en = cmp.key_eq;
        efkt_pkg::OP_QUERY: clr_en = cmp.expired;
        default:            clr_en = 1'b0;
      endcase
    end
  end

  // live match, else first free slot, else oldest stamp
  always_comb begin
    if (match_found) begin
      victim = match_idx;
    end else if (free_found) begin
      victim = free_idx;
    end else begin
      victim = old_idx;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      efkt_pkg::ST_IDLE: begin
        if (accept) begin
          if (opcode == efkt_pkg::OP_MARK || opcode == efkt_pkg::OP_CLEAR ||
              opcode == efkt_pkg::OP_QUERY) begin
            state_next = efkt_pkg::ST_SCAN;
          end else begin
            state_next = efkt_pkg::ST_RESP;
          end
        end
      end
      efkt_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = (cur_op == efkt_pkg::OP_MARK) ? efkt_pkg::ST_WRITE
                                                     : efkt_pkg::ST_RESP;
        end
      end
      efkt_pkg::ST_WRITE: state_next = efkt_pkg::ST_RESP;
      efkt_pkg::ST_RESP: begin
        if (out_load) begin
          state_next = efkt_pkg::ST_IDLE;
        end
      end
      default: state_next = efkt_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      efkt_pkg::ST_IDLE:  in_ready = 1'b1;
      efkt_pkg::ST_SCAN:  ram_re   = (rd_ptr != CNT_END) && !scan_done;
      efkt_pkg::ST_WRITE: ram_we   = 1'b1;
      efkt_pkg::ST_RESP:  out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efkt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry <= efkt_pkg::EXPIRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      expiry <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op  <= opcode;
      cur_key <= key;
      cur_now <= time_now;
    end
  end

  // scan sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      pend   <= 1'b0;
    end else if (accept) begin
      rd_ptr <= '0;
      pend   <= 1'b0;
    end else begin
      pend <= ram_re;
      if (ram_re) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      chk_ptr <= rd_ptr[IDX_W-1:0];
    end
  end

  // findings for mark and query
  always_ff @(posedge clk) begin
    if (rst || accept) begin
      hit         <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      old_found   <= 1'b0;
    end else if (eval) begin
      if (q_hit) begin
        hit <= 1'b1;
      end
      if (cur_op == efkt_pkg::OP_MARK) begin
        if (ent_v && cmp.key_eq && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= chk_ptr;
        end
        if (!ent_v && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= chk_ptr;
        end
        // strict compare keeps the lowest index on ties
        if (ent_v && (!old_found || cmp.older)) begin
          old_found <= 1'b1;
          old_idx   <= chk_ptr;
          old_stamp <= ram_stamp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else begin
      if (clr_en) begin
        entry_valid[chk_ptr] <= 1'b0;
      end
      if (ram_we) begin
        entry_valid[victim] <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      is_full <= hit;
    end
  end

endmodule

[hdl/efkt_checker.sv]
// Port-level checker for the expiring full-key table, bound to the top level.
module efkt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic is_full
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_full))
    else $error("result beat changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // no result appears the cycle right after an accept
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  // reset leaves the block idle and empty
  a_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind expiring_full_key_table efkt_checker u_efkt_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .is_full  (is_full)
);

[bench/expiring_full_key_table_test.sv]
// Self-checking bench for the expiring full-key table: directed cases, then random traffic.
module expiring_full_key_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [efkt_pkg::KEY_WIDTH_DEF-1:0] key_t;
  typedef logic [efkt_pkg::STAMP_W-1:0]       stamp_t;
  typedef logic [efkt_pkg::EXP_W-1:0]         expiry_t;
  typedef logic [efkt_pkg::OP_W-1:0]          op_t;

  // opcode 3 has no package name; the block must ignore it
  localparam op_t OP_UNUSED = 2'd3;

  localparam int ITEMS_PER_SEGMENT = 161;
  localparam int DRAIN_CYCLES      = efkt_pkg::ENTRIES_DEF + 8;

  // ---------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  op_t             opcode    = efkt_pkg::OP_MARK;
  key_t            key       = '0;
  stamp_t          time_now  = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic            is_full;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  expiry_t         cfg_data  = '0;

  expiring_full_key_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .key       (key),
    .time_now  (time_now),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_full   (is_full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the table and its expiry register
  // ---------------------------------------------------------------------------
  logic    shadow_valid [efkt_pkg::ENTRIES_DEF];
  key_t    shadow_key   [efkt_pkg::ENTRIES_DEF];
  stamp_t  shadow_stamp [efkt_pkg::ENTRIES_DEF];
  expiry_t expiry_setting = efkt_pkg::EXPIRY_RESET;

  // is_full values still owed by the DUT, oldest first
  logic full_expected [$];
  logic want_full;
  int   mismatch_count = 0;

  // idle chances in percent, changed per traffic phase
  int send_idle_pct = 29;
  int recv_idle_pct = 45;

  // random traffic state
  key_t   key_pool [6];
  stamp_t cur_time;

  // Apply one beat to the shadow table and return the is_full it should give.
  function automatic logic table_update(input op_t op, input key_t k,
                                        input stamp_t now);
    int     victim;
    int     oldest;
    longint age;
    victim = -1;
    oldest = 0;
    case (op)
      efkt_pkg::OP_MARK: begin
        // a live match only gets a new stamp
        for (int i = 0; i < efkt_pkg::ENTRIES_DEF; i++) begin
          if (shadow_valid[i] && shadow_key[i] == k) begin
            shadow_stamp[i] = now;
            return 1'b0;
          end
        end
        // first free slot; else oldest stamp, lowest index on a tie
        for (int i = 0; i < efkt_pkg::ENTRIES_DEF; i++) begin
          if (!shadow_valid[i]) begin
            victim = i;
            break;
          end
          if (shadow_stamp[i] < shadow_stamp[oldest]) oldest = i;
        end
        if (victim < 0) victim = oldest;
        shadow_valid[victim] = 1'b1;
        shadow_key[victim]   = k;
        shadow_stamp[victim] = now;
        return 1'b0;
      end
      efkt_pkg::OP_CLEAR: begin
        for (int i = 0; i < efkt_pkg::ENTRIES_DEF; i++)
          if (shadow_valid[i] && shadow_key[i] == k) shadow_valid[i] = 1'b0;
        return 1'b0;
      end
      efkt_pkg::OP_QUERY: begin
        // scan stops at the first live hit, so later stale entries survive
        for (int i = 0; i < efkt_pkg::ENTRIES_DEF; i++) begin
          if (!shadow_valid[i]) continue;
          // full-width difference: a stamp ahead of now gives a negative age
          age = longint'(now) - longint'(shadow_stamp[i]);
          if (age > longint'(expiry_setting)) begin
            shadow_valid[i] = 1'b0;
            continue;
          end
          if (shadow_key[i] == k) return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and the compare against the oldest entry
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (full_expected.size() == 0) begin
        $error("is_full: expected no beat, actual %0d", is_full);
        mismatch_count++;
      end else begin
        want_full = full_expected.pop_front();
        if (is_full !== want_full) begin
          $error("is_full: expected %0d, actual %0d", want_full, is_full);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // One input beat. in_valid is only dropped in an idle gap, never lowered and
  // raised in the same step between back-to-back beats.
  task automatic send_item(input op_t op, input key_t k, input stamp_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    key      <= k;
    time_now <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    full_expected.push_back(table_update(op, k, t));
  endtask

  // Stop sending, collect every owed result, then let the scan pipeline settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (full_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write, only ever with the block idle.
  task automatic write_expiry(input expiry_t value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid      <= 1'b0;
    expiry_setting  = value;
  endtask

  function automatic key_t rand_key();
    return key_t'({$urandom, $urandom});
  endfunction

  // ---------------------------------------------------------------------------
  // Directed tests (run at the reset expiry of 60 unless noted)
  // ---------------------------------------------------------------------------
  task automatic test_empty_query();
    send_item(efkt_pkg::OP_QUERY, '0, '0);
  endtask

  // zero time is an ordinary stamp; age equal to the expiry is still live
  task automatic test_mark_and_refresh();
    send_item(efkt_pkg::OP_MARK,  '1, 32'd0);
    send_item(efkt_pkg::OP_QUERY, '1, 32'd60);
    send_item(efkt_pkg::OP_MARK,  '1, 32'd50);
    send_item(efkt_pkg::OP_QUERY, '1, 32'd110);
  endtask

  // fill the table, then force an eviction of the oldest stamp
  task automatic test_replacement();
    send_item(efkt_pkg::OP_MARK,  '0, 32'd10);
    send_item(efkt_pkg::OP_MARK,  key_t'(64'h5555_AAAA_0F0F_F0F0), 32'd20);
    send_item(efkt_pkg::OP_MARK,  key_t'(64'hAAAA_5555_F0F0_0F0F), 32'd30);
    send_item(efkt_pkg::OP_MARK,  key_t'(64'h8000_0000_0000_0001), 32'd40);
    send_item(efkt_pkg::OP_QUERY, '0, 32'd40);
    send_item(efkt_pkg::OP_QUERY, key_t'(64'h8000_0000_0000_0001), 32'd40);
  endtask

  // early hit leaves stale entries behind; a later miss sweeps them
  task automatic test_query_sweep();
    send_item(efkt_pkg::OP_QUERY, '1, 32'd85);
    send_item(efkt_pkg::OP_QUERY, key_t'(64'hAAAA_5555_F0F0_0F0F), 32'd91);
    // stamp ahead of now never expires
    send_item(efkt_pkg::OP_MARK,  key_t'(64'h0123_4567_89AB_CDEF), 32'hFFFF_FFF0);
    send_item(efkt_pkg::OP_QUERY, key_t'(64'h0123_4567_89AB_CDEF), 32'd5);
  endtask

  task automatic test_clear_and_unused();
    send_item(efkt_pkg::OP_CLEAR, key_t'(64'h8000_0000_0000_0001), 32'hFFFF_FFFF);
    send_item(efkt_pkg::OP_QUERY, key_t'(64'h8000_0000_0000_0001), 32'd45);
    send_item(OP_UNUSED,          '1, 32'hFFFF_FFFF);
    send_item(efkt_pkg::OP_QUERY, '1, 32'd60);
  endtask

  // expiry register at both ends of its range
  task automatic test_expiry_extremes();
    write_expiry('0);
    send_item(efkt_pkg::OP_MARK,  key_t'(64'hDEAD_BEEF_0000_0007), 32'd100);
    send_item(efkt_pkg::OP_QUERY, key_t'(64'hDEAD_BEEF_0000_0007), 32'd100);
    send_item(efkt_pkg::OP_QUERY, key_t'(64'hDEAD_BEEF_0000_0007), 32'd101);
    write_expiry('1);
    send_item(efkt_pkg::OP_MARK,  key_t'(64'h0000_0000_FFFF_0000), 32'd0);
    send_item(efkt_pkg::OP_QUERY, key_t'(64'h0000_0000_FFFF_0000), 32'd65535);
    send_item(efkt_pkg::OP_QUERY, key_t'(64'h0000_0000_FFFF_0000), 32'd65536);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------
  // Six keys for four entries keeps hits and evictions common; one key sits a
  // single bit away from another to catch partial compares.
  task automatic refill_key_pool();
    for (int i = 0; i < 5; i++) key_pool[i] = rand_key();
    key_pool[5] = key_pool[0] ^
                  (key_t'(1) << $urandom_range(efkt_pkg::KEY_WIDTH_DEF - 1));
  endtask

  task automatic run_random_items(input int count);
    op_t  op;
    key_t k;
    int   r;
    int   step_lim;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 35)      op = efkt_pkg::OP_MARK;
      else if (r < 50) op = efkt_pkg::OP_CLEAR;
      else if (r < 95) op = efkt_pkg::OP_QUERY;
      else             op = OP_UNUSED;

      r = $urandom_range(99);
      if (r < 85)      k = key_pool[$urandom_range(5)];
      else if (r < 95) k = rand_key();
      else             k = ($urandom_range(1) != 0) ? '1 : '0;

      // time mostly creeps forward around the expiry window, with holds,
      // small steps back, and rare jumps anywhere (wrap included)
      step_lim = int'(expiry_setting) + int'(expiry_setting) / 2 + 2;
      r = $urandom_range(99);
      if (r < 5)       cur_time = $urandom;
      else if (r < 30) cur_time = cur_time;
      else if (r < 35) cur_time = cur_time - stamp_t'($urandom_range(step_lim));
      else             cur_time = cur_time + stamp_t'($urandom_range(step_lim));

      send_item(op, k, cur_time);
    end
  endtask

  task automatic test_random_traffic();
    expiry_t exp_pick [9];
    exp_pick[0] = '0;
    exp_pick[1] = '1;
    exp_pick[2] = efkt_pkg::EXPIRY_RESET;
    exp_pick[3] = 16'd1;
    exp_pick[4] = 16'd5;
    exp_pick[5] = expiry_t'($urandom);
    exp_pick[6] = 16'd30;
    exp_pick[7] = 16'd65534;
    exp_pick[8] = expiry_t'($urandom_range(200));
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 29; recv_idle_pct = 45; end
        1: begin send_idle_pct = 45; recv_idle_pct = 29; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        write_expiry(exp_pick[phase * 3 + seg]);
        refill_key_pool();
        cur_time = ($urandom_range(3) == 0) ? stamp_t'($urandom)
                                            : stamp_t'($urandom_range(1000));
        run_random_items(ITEMS_PER_SEGMENT);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < efkt_pkg::ENTRIES_DEF; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_stamp[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_query();
    test_mark_and_refresh();
    test_replacement();
    test_query_sweep();
    test_clear_and_unused();
    test_expiry_extremes();
    test_random_traffic();

    drain_results();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit for a run that hangs
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
hdl/efkt_pkg.sv
hdl/efkt_entry_ram.sv
hdl/efkt_cmp_unit.sv
hdl/expiring_full_key_table.sv
hdl/efkt_checker.sv
bench/expiring_full_key_table_test.sv
